[hw/rtl/tcp_pkg.sv]
// ----------------------------------------------------------------------------
// tcp_pkg: shared definitions for the tile constraint propagator
// Operation codes, configuration register indexes, direction codes, widths and a population count.
// ----------------------------------------------------------------------------
package tcp_pkg;

    localparam int unsigned OP_W   = 3;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned GEO_W  = 9;
    localparam int unsigned DIRS   = 4;

    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
    localparam logic [OP_W-1:0] OP_BAN   = 3'd2;
    localparam logic [OP_W-1:0] OP_PROP  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

    localparam logic [1:0] REG_ROWS = 2'd0;
    localparam logic [1:0] REG_COLS = 2'd1;
    localparam logic [1:0] REG_PATS = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    function automatic logic [CNT_W-1:0] popcount64(input logic [63:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < 64; i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

[hw/rtl/tile_constraint_propagator.sv]
// ----------------------------------------------------------------------------
// tile_constraint_propagator: grid constraint propagator
// Cell options, support counts, rules and the pending stack live in memories.
// ----------------------------------------------------------------------------
// Clear builds support templates from the rules, then fills the support and
// options memories of every cell in use; propagate pops pending entries and
// finds each entry's row and column with a serial divider before it updates
// the neighbors. One request is handled at a time; a new one is taken while
// a result waits.
// After reset a pass over all MAX_ROWS*MAX_COLS cells zeroes the options memory.
module tile_constraint_propagator #(
    parameter int unsigned MAX_ROWS     = 32,
    parameter int unsigned MAX_COLS     = 32,
    parameter int unsigned MAX_PATTERNS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [6:0]              i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [tcp_pkg::OP_W-1:0] i_op,
    input  logic [4:0]              i_cell_row,
    input  logic [4:0]              i_cell_col,
    input  logic [5:0]              i_pattern,
    input  logic [1:0]              i_direction,
    input  logic [63:0]             i_rule_mask,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [63:0]             o_options_mask,
    output logic [tcp_pkg::CNT_W-1:0] o_options_left,
    output logic                    o_contradiction
);
    import tcp_pkg::*;

    localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
    localparam int unsigned IDXW  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int unsigned PW    = $clog2(MAX_PATTERNS);
    localparam int unsigned NR    = MAX_PATTERNS * DIRS;
    localparam int unsigned RAW   = PW + 2;
    localparam int unsigned CAP   = CELLS * MAX_PATTERNS;
    localparam int unsigned SAW   = $clog2(CAP);
    localparam int unsigned SDW   = $clog2(CAP + 1);
    localparam int unsigned CTW   = $clog2(CELLS * DIRS + NR + 1);
    localparam int unsigned NW    = ((IDXW > GEO_W) ? IDXW : GEO_W) + 1;
    localparam int unsigned EW    = IDXW + PW;
    localparam int unsigned SUPA  = IDXW + 2;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLR_TMPL, S_CLR_FILL, S_BAN_ISS, S_BAN_CHK,
        S_Q_ISS, S_Q_CHK, S_POP, S_POP_WAIT, S_DIV, S_DIR, S_NB_ISS,
        S_NB_UPD, S_PUSH, S_DONE
    } t_state;

    typedef logic [MAX_PATTERNS-1:0][CNT_W-1:0] t_sup_row;

    // Memories.
    logic [MAX_PATTERNS-1:0] mem_opt  [CELLS];
    t_sup_row                mem_sup  [CELLS*DIRS];
    logic [MAX_PATTERNS-1:0] mem_rule [NR];
    logic [EW-1:0]           mem_stk  [CAP];

    logic                    opt_we, opt_re, sup_we, sup_re, rule_we, rule_re;
    logic                    stk_we, stk_re;
    logic [IDXW-1:0]         opt_waddr, opt_raddr;
    logic [MAX_PATTERNS-1:0] opt_wdata;
    logic [SUPA-1:0]         sup_waddr, sup_raddr;
    t_sup_row                sup_wdata;
    logic [RAW-1:0]          rule_waddr, rule_raddr;
    logic [MAX_PATTERNS-1:0] rule_wdata;
    logic [SAW-1:0]          stk_waddr, stk_raddr;
    logic [EW-1:0]           stk_wdata;

    logic [MAX_PATTERNS-1:0] r_opt_q;
    t_sup_row                r_sup_q;
    logic [MAX_PATTERNS-1:0] r_rule_q;
    logic [EW-1:0]           r_stk_q;

    // Configuration registers.
    logic [5:0] r_rows, r_cols;
    logic [6:0] r_pats;

    // Control and datapath registers.
    t_state                  r_state;
    logic [CTW-1:0]          r_cnt;
    logic [CTW-1:0]          r_fill_last;
    logic [IDXW-1:0]         r_idx;
    logic [5:0]              r_pat;
    logic [SDW-1:0]          r_sdepth;
    logic                    r_flag;
    logic [MAX_PATTERNS-1:0] r_res;
    logic                    r_ovalid;
    logic [63:0]             r_omask;
    logic [CNT_W-1:0]        r_oleft;
    logic                    r_oflag;
    logic [IDXW-1:0]         r_dvd;
    logic [GEO_W:0]          r_rem;
    logic [$clog2(IDXW+1)-1:0] r_dcnt;
    logic [1:0]              r_dir;
    logic [IDXW-1:0]         r_nidx;
    logic [MAX_PATTERNS-1:0] r_zero;
    t_sup_row                r_tmpl [DIRS];

    // Geometry in use.
    logic [GEO_W-1:0]        rows_used, cols_used;
    logic [CNT_W-1:0]        pats_used;
    logic [MAX_PATTERNS-1:0] pm;

    always_comb begin
        if (r_rows == '0) begin
            rows_used = GEO_W'(1);
        end else if (GEO_W'(r_rows) > GEO_W'(MAX_ROWS)) begin
            rows_used = GEO_W'(MAX_ROWS);
        end else begin
            rows_used = GEO_W'(r_rows);
        end
        if (r_cols == '0) begin
            cols_used = GEO_W'(1);
        end else if (GEO_W'(r_cols) > GEO_W'(MAX_COLS)) begin
            cols_used = GEO_W'(MAX_COLS);
        end else begin
            cols_used = GEO_W'(r_cols);
        end
        if (r_pats == '0) begin
            pats_used = CNT_W'(1);
        end else if (r_pats > CNT_W'(MAX_PATTERNS)) begin
            pats_used = CNT_W'(MAX_PATTERNS);
        end else begin
            pats_used = r_pats;
        end
        for (int i = 0; i < MAX_PATTERNS; i++) begin
            pm[i] = (CNT_W'(i) < pats_used);
        end
    end

    // Request decode at the input.
    logic            accept;
    logic            in_grid;
    logic [IDXW-1:0] in_idx;
    logic [18:0]     in_idx_wide;

    assign accept      = i_in_valid && !o_in_stall;
    assign in_grid     = (GEO_W'(i_cell_row) < rows_used) && (GEO_W'(i_cell_col) < cols_used);
    assign in_idx_wide = 19'(i_cell_row) * 19'(cols_used) + 19'(i_cell_col);
    assign in_idx      = in_idx_wide[IDXW-1:0];

    // Neighbor geometry for the current direction.
    logic [NW-1:0]  nb_row, nb_col;
    logic           nb_in;
    logic [NW+GEO_W-1:0] nb_prod;
    logic [NW-1:0]  row_w, col_w;

    always_comb begin
        row_w  = NW'(r_dvd);
        col_w  = NW'(r_rem[GEO_W-1:0]);
        nb_row = row_w;
        nb_col = col_w;
        nb_in  = 1'b0;
        unique case (r_dir)
            DIR_UP: begin
                nb_row = row_w - NW'(1);
                nb_in  = (row_w != '0);
            end
            DIR_RIGHT: begin
                nb_col = col_w + NW'(1);
                nb_in  = 1'b1;
            end
            DIR_DOWN: begin
                nb_row = row_w + NW'(1);
                nb_in  = 1'b1;
            end
            DIR_LEFT: begin
                nb_col = col_w - NW'(1);
                nb_in  = (col_w != '0);
            end
            default: nb_in = 1'b0;
        endcase
        nb_in   = nb_in && (nb_row < NW'(rows_used)) && (nb_col < NW'(cols_used));
        nb_prod = (NW+GEO_W)'(nb_row) * (NW+GEO_W)'(cols_used) + (NW+GEO_W)'(nb_col);
    end

    // Support update for one neighbor row.
    t_sup_row                upd_sup;
    logic [MAX_PATTERNS-1:0] upd_zero;
    logic [MAX_PATTERNS-1:0] upd_opt;

    always_comb begin
        logic             act;
        logic [CNT_W-1:0] nc;
        for (int k = 0; k < MAX_PATTERNS; k++) begin
            act = r_rule_q[k] && pm[k] && r_opt_q[k];
            nc  = (r_sup_q[k] == '0) ? '0 : r_sup_q[k] - CNT_W'(1);
            upd_sup[k]  = act ? nc : r_sup_q[k];
            upd_zero[k] = act && (nc == '0);
        end
        upd_opt = r_opt_q & ~upd_zero;
    end

    // Lowest pending removal to push.
    logic [PW-1:0]           push_k;
    logic [MAX_PATTERNS-1:0] push_clr;

    always_comb begin
        push_k   = '0;
        push_clr = r_zero;
        for (int k = MAX_PATTERNS - 1; k >= 0; k--) begin
            if (r_zero[k]) begin
                push_k = PW'(k);
            end
        end
        push_clr[push_k] = 1'b0;
    end

    logic [CNT_W-1:0] tmpl_cnt;
    logic [63:0]      tmpl_w;
    logic [CTW-1:0]   tmpl_e;
    logic [63:0]      res_w;
    logic             stk_room;
    logic [GEO_W:0]   div_sh;

    always_comb begin
        tmpl_w = '0;
        tmpl_w[MAX_PATTERNS-1:0] = r_rule_q & pm;
        tmpl_cnt = popcount64(tmpl_w);
        res_w = '0;
        res_w[MAX_PATTERNS-1:0] = r_res;
    end

    assign tmpl_e   = r_cnt - CTW'(1);
    assign stk_room = (r_sdepth < SDW'(CAP));
    assign div_sh   = {r_rem[GEO_W-1:0], r_dvd[IDXW-1]};

    // Memory control.
    always_comb begin
        opt_we = 1'b0; opt_re = 1'b0; opt_waddr = r_idx; opt_raddr = r_idx;
        opt_wdata = '0;
        sup_we = 1'b0; sup_re = 1'b0;
        sup_waddr = {r_nidx, r_dir ^ 2'b10}; sup_raddr = {r_nidx, r_dir ^ 2'b10};
        sup_wdata = upd_sup;
        rule_we = 1'b0; rule_re = 1'b0;
        rule_waddr = {i_pattern[PW-1:0], i_direction};
        rule_raddr = {r_pat[PW-1:0], r_dir};
        rule_wdata = i_rule_mask[MAX_PATTERNS-1:0];
        stk_we = 1'b0; stk_re = 1'b0;
        stk_waddr = r_sdepth[SAW-1:0]; stk_raddr = r_sdepth[SAW-1:0] - SAW'(1);
        stk_wdata = {r_nidx, push_k};
        unique case (r_state)
            S_INIT: begin
                opt_we    = 1'b1;
                opt_waddr = r_cnt[IDXW-1:0];
            end
            S_IDLE: begin
                rule_we = accept && (i_op == OP_LOAD) && (7'(i_pattern) < 7'(MAX_PATTERNS));
            end
            S_CLR_TMPL: begin
                rule_re    = (r_cnt < CTW'(NR));
                rule_raddr = r_cnt[RAW-1:0];
            end
            S_CLR_FILL: begin
                sup_we    = 1'b1;
                sup_waddr = r_cnt[SUPA-1:0];
                sup_wdata = r_tmpl[r_cnt[1:0]];
                opt_we    = (r_cnt[1:0] == 2'b00);
                opt_waddr = r_cnt[SUPA-1:2];
                opt_wdata = pm;
            end
            S_BAN_ISS, S_Q_ISS: opt_re = 1'b1;
            S_BAN_CHK: begin
                opt_we    = r_opt_q[r_pat[PW-1:0]];
                opt_wdata = r_opt_q & ~(MAX_PATTERNS'(1) << r_pat[PW-1:0]);
                stk_we    = r_opt_q[r_pat[PW-1:0]] && stk_room;
                stk_wdata = {r_idx, r_pat[PW-1:0]};
            end
            S_POP: stk_re = (r_sdepth != '0);
            S_NB_ISS: begin
                opt_re    = 1'b1;
                opt_raddr = r_nidx;
                sup_re    = 1'b1;
                rule_re   = 1'b1;
            end
            S_NB_UPD: begin
                opt_we    = 1'b1;
                opt_waddr = r_nidx;
                opt_wdata = upd_opt;
                sup_we    = 1'b1;
            end
            S_PUSH: stk_we = (r_zero != '0) && stk_room;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (opt_we) mem_opt[opt_waddr] <= opt_wdata;
        if (opt_re) r_opt_q <= mem_opt[opt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sup_we) mem_sup[sup_waddr] <= sup_wdata;
        if (sup_re) r_sup_q <= mem_sup[sup_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rule_we) mem_rule[rule_waddr] <= rule_wdata;
        if (rule_re) r_rule_q <= mem_rule[rule_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) mem_stk[stk_waddr] <= stk_wdata;
        if (stk_re) r_stk_q <= mem_stk[stk_raddr];
    end

    // Support templates built during clear.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR_TMPL && r_cnt != '0) begin
            r_tmpl[tmpl_e[1:0]][tmpl_e[RAW-1:2]] <= tmpl_cnt;
        end
    end

    // Configuration port.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 6'd32;
            r_cols <= 6'd32;
            r_pats <= 7'd64;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROWS: r_rows <= i_cfg_data[5:0];
                REG_COLS: r_cols <= i_cfg_data[5:0];
                REG_PATS: r_pats <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Main sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cnt    <= '0;
            r_sdepth <= '0;
            r_flag   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + CTW'(1);
                    if (r_cnt == CTW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_idx <= in_idx;
                        r_pat <= i_pattern;
                        r_res <= '0;
                        r_cnt <= '0;
                        r_fill_last <= CTW'((32'(rows_used) * 32'(cols_used)) * DIRS - 1);
                        unique case (i_op)
                            OP_CLEAR: r_state <= S_CLR_TMPL;
                            OP_BAN: begin
                                r_state <= (in_grid && (7'(i_pattern) < pats_used))
                                           ? S_BAN_ISS : S_DONE;
                            end
                            OP_PROP:  r_state <= S_POP;
                            OP_QUERY: r_state <= in_grid ? S_Q_ISS : S_DONE;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_CLR_TMPL: begin
                    r_cnt <= r_cnt + CTW'(1);
                    if (r_cnt == CTW'(NR)) begin
                        r_cnt   <= '0;
                        r_state <= S_CLR_FILL;
                    end
                end
                S_CLR_FILL: begin
                    r_cnt <= r_cnt + CTW'(1);
                    if (r_cnt == r_fill_last) begin
                        r_sdepth <= '0;
                        r_flag   <= 1'b0;
                        r_state  <= S_DONE;
                    end
                end
                S_BAN_ISS: r_state <= S_BAN_CHK;
                S_BAN_CHK: begin
                    if (r_opt_q[r_pat[PW-1:0]]) begin
                        if ((r_opt_q & ~(MAX_PATTERNS'(1) << r_pat[PW-1:0])) == '0) begin
                            r_flag <= 1'b1;
                        end
                        if (stk_room) begin
                            r_sdepth <= r_sdepth + SDW'(1);
                        end
                    end
                    r_state <= S_DONE;
                end
                S_Q_ISS: r_state <= S_Q_CHK;
                S_Q_CHK: begin
                    r_res   <= r_opt_q;
                    r_state <= S_DONE;
                end
                S_POP: begin
                    if (r_sdepth == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_sdepth <= r_sdepth - SDW'(1);
                        r_state  <= S_POP_WAIT;
                    end
                end
                S_POP_WAIT: begin
                    r_dvd   <= r_stk_q[EW-1:PW];
                    r_pat   <= 6'(r_stk_q[PW-1:0]);
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_dir   <= DIR_UP;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // Restoring division of the cell index by the column count.
                    if (div_sh >= (GEO_W+1)'(cols_used)) begin
                        r_rem <= div_sh - (GEO_W+1)'(cols_used);
                        r_dvd <= {r_dvd[IDXW-2:0], 1'b1};
                    end else begin
                        r_rem <= div_sh;
                        r_dvd <= {r_dvd[IDXW-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == $bits(r_dcnt)'(IDXW - 1)) begin
                        r_state <= S_DIR;
                    end
                end
                S_DIR: begin
                    if (nb_in) begin
                        r_nidx  <= nb_prod[IDXW-1:0];
                        r_state <= S_NB_ISS;
                    end else if (r_dir == DIR_LEFT) begin
                        r_state <= S_POP;
                    end else begin
                        r_dir <= r_dir + 2'd1;
                    end
                end
                S_NB_ISS: r_state <= S_NB_UPD;
                S_NB_UPD: begin
                    if ((upd_zero != '0) && (upd_opt == '0)) begin
                        r_flag <= 1'b1;
                    end
                    r_zero  <= upd_zero;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (r_zero != '0) begin
                        r_zero <= push_clr;
                        if (stk_room) begin
                            r_sdepth <= r_sdepth + SDW'(1);
                        end
                    end else if (r_dir == DIR_LEFT) begin
                        r_state <= S_POP;
                    end else begin
                        r_dir   <= r_dir + 2'd1;
                        r_state <= S_DIR;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid <= 1'b1;
                        r_omask  <= res_w;
                        r_oleft  <= popcount64(res_w);
                        r_oflag  <= r_flag;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_options_mask  = r_omask;
    assign o_options_left  = r_oleft;
    assign o_contradiction = r_oflag;

endmodule

[tb/tile_constraint_propagator_tb.sv]
// ----------------------------------------------------------------------------
// tile_constraint_propagator_tb: self-checking testbench for the propagator
// Drives rule loads, clears, bans, propagations and queries through the
// request channel, mirrors the grid, support counts and pending stack in a
// local predictor, and checks every result in order under random stalls.
// ----------------------------------------------------------------------------
module tile_constraint_propagator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcp_pkg::*;

    localparam int unsigned NPAT       = 64;
    localparam int unsigned NCELL      = 1024;
    localparam longint     CYCLE_LIMIT = 40_000_000;

    typedef struct packed {
        logic [63:0] mask;
        logic [6:0]  left;
        logic        contra;
    } grid_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [6:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_op;
    logic [4:0]  i_cell_row;
    logic [4:0]  i_cell_col;
    logic [5:0]  i_pattern;
    logic [1:0]  i_direction;
    logic [63:0] i_rule_mask;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_options_mask;
    logic [6:0]  o_options_left;
    logic        o_contradiction;

    tile_constraint_propagator uut (.*);

    // Mirror of the block state.
    logic [6:0]  m_rows, m_cols, m_pats;
    logic [63:0] m_rules [0:NPAT*4-1];
    logic [6:0]  m_support [0:NCELL-1][0:NPAT-1][0:3];
    logic [63:0] m_options [0:NCELL-1];
    int          pending_cells [$];
    logic        m_empty;

    grid_result_t expected_results [$];
    int     error_count = 0;
    longint cycle_count = 0;
    int     long_hold = 0;
    bit     burst_mode = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_to(logic [6:0] v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic logic [63:0] used_mask();
        int n;
        n = clamp_to(m_pats, NPAT);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic void drop_option(int idx, int p);
        m_options[idx][p] = 1'b0;
        for (int d = 0; d < 4; d++) m_support[idx][p][d] = '0;
        if (m_options[idx] == '0) m_empty = 1'b1;
        if (pending_cells.size() < NCELL * NPAT) pending_cells.push_back(idx * NPAT + p);
    endfunction

    function automatic void clear_grid();
        int rows, cols, np;
        logic [63:0] pm;
        rows = clamp_to(m_rows, 32);
        cols = clamp_to(m_cols, 32);
        np = clamp_to(m_pats, NPAT);
        pm = used_mask();
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                m_options[r * cols + c] = pm;
                for (int p = 0; p < np; p++) begin
                    for (int d = 0; d < 4; d++) begin
                        m_support[r * cols + c][p][d] = 7'($countones(m_rules[p * 4 + d] & pm));
                    end
                end
            end
        end
        pending_cells.delete();
        m_empty = 1'b0;
    endfunction

    function automatic void propagate_bans();
        int rows, cols, entry, idx, p, r, c, nr, nc, nidx;
        logic [63:0] pm, allowed;
        logic [6:0] cnt;
        rows = clamp_to(m_rows, 32);
        cols = clamp_to(m_cols, 32);
        pm = used_mask();
        while (pending_cells.size() > 0) begin
            entry = pending_cells.pop_back();
            idx = entry / NPAT;
            p = entry % NPAT;
            r = idx / cols;
            c = idx % cols;
            for (int d = 0; d < 4; d++) begin
                nr = r;
                nc = c;
                case (2'(d))
                    DIR_UP:    nr = r - 1;
                    DIR_RIGHT: nc = c + 1;
                    DIR_DOWN:  nr = r + 1;
                    DIR_LEFT:  nc = c - 1;
                endcase
                if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
                nidx = nr * cols + nc;
                allowed = m_rules[p * 4 + d] & pm;
                for (int k = 0; k < 64; k++) begin
                    if (!allowed[k] || !m_options[nidx][k]) continue;
                    cnt = m_support[nidx][k][d ^ 2];
                    if (cnt > 0) cnt = cnt - 1;
                    m_support[nidx][k][d ^ 2] = cnt;
                    if (cnt == 0) drop_option(nidx, k);
                end
            end
        end
    endfunction

    function automatic grid_result_t predict_request(logic [2:0] op, logic [4:0] row,
            logic [4:0] col, logic [5:0] pat, logic [1:0] dir, logic [63:0] mask);
        grid_result_t res;
        bit in_grid;
        int idx;
        in_grid = (row < clamp_to(m_rows, 32)) && (col < clamp_to(m_cols, 32));
        idx = in_grid ? row * clamp_to(m_cols, 32) + col : 0;
        res.mask = '0;
        case (op)
            OP_LOAD:  m_rules[pat * 4 + dir] = mask;
            OP_CLEAR: clear_grid();
            OP_BAN: begin
                if (in_grid && pat < clamp_to(m_pats, NPAT) && m_options[idx][pat])
                    drop_option(idx, pat);
            end
            OP_PROP:  propagate_bans();
            OP_QUERY: if (in_grid) res.mask = m_options[idx];
            default: ;
        endcase
        res.left = 7'($countones(res.mask));
        res.contra = m_empty;
        return res;
    endfunction

    // Most gaps are zero or short; now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 50) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_request(logic [2:0] op, logic [4:0] row, logic [4:0] col,
            logic [5:0] pat, logic [1:0] dir, logic [63:0] mask);
        int gap;
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_cell_row  <= row;
        i_cell_col  <= col;
        i_pattern   <= pat;
        i_direction <= dir;
        i_rule_mask <= mask;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_request(op, row, col, pat, dir, mask));
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [6:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            REG_ROWS: m_rows = data & 7'h3F;
            REG_COLS: m_cols = data & 7'h3F;
            REG_PATS: m_pats = data;
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [6:0] rows, logic [6:0] cols, logic [6:0] pats);
        wait_drained();
        write_register(REG_ROWS, rows);
        write_register(REG_COLS, cols);
        write_register(REG_PATS, pats);
    endtask

    function automatic logic [63:0] random_rule(int density);
        logic [63:0] a, b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case (density)
            0: return a & b;
            1: return a | b;
            default: return a;
        endcase
    endfunction

    // Every rule is written before anything reads the table.
    task automatic test_rule_table();
        for (int p = 0; p < NPAT; p++) begin
            for (int d = 0; d < 4; d++) begin
                if (p == 0 && d == 0) send_request(OP_LOAD, '0, '0, 6'(p), 2'(d), '1);
                else if (p == 1 && d == 0) send_request(OP_LOAD, '1, '1, 6'(p), 2'(d), '0);
                else send_request(OP_LOAD, 5'($urandom), 5'($urandom), 6'(p), 2'(d),
                                  random_rule($urandom_range(0, 2)));
            end
        end
    endtask

    task automatic test_full_grid();
        send_request(OP_CLEAR, '0, '0, '0, '0, '0);
        send_request(OP_QUERY, 5'd0, 5'd0, '0, '0, '0);
        send_request(OP_QUERY, 5'd31, 5'd31, '0, '0, '0);
        send_request(OP_BAN, 5'd31, 5'd31, 6'd63, '0, '0);
        send_request(OP_QUERY, 5'd31, 5'd31, '0, '0, '0);
    endtask

    task automatic test_ban_cases();
        set_geometry(7'd3, 7'd4, 7'd5);
        send_request(OP_LOAD, '0, '0, 6'd2, DIR_RIGHT, '1);
        send_request(OP_CLEAR, '0, '0, '0, '0, '0);
        send_request(OP_BAN, 5'd5, 5'd0, 6'd1, '0, '0);
        send_request(OP_BAN, 5'd0, 5'd0, 6'd60, '0, '0);
        send_request(OP_BAN, 5'd1, 5'd1, 6'd2, '0, '0);
        send_request(OP_BAN, 5'd1, 5'd1, 6'd2, '0, '0);
        send_request(OP_PROP, '0, '0, '0, '0, '0);
        send_request(OP_QUERY, 5'd1, 5'd1, '0, '0, '0);
        send_request(OP_QUERY, 5'd1, 5'd2, '0, '0, '0);
        send_request(OP_QUERY, 5'd0, 5'd5, '0, '0, '0);
        for (int k = int'(OP_QUERY) + 1; k < 8; k++)
            send_request(3'(k), '1, '1, '1, '1, '1);
    endtask

    task automatic test_contradiction();
        set_geometry(7'd2, 7'd2, 7'd2);
        send_request(OP_CLEAR, '0, '0, '0, '0, '0);
        send_request(OP_BAN, 5'd0, 5'd0, 6'd0, '0, '0);
        send_request(OP_BAN, 5'd0, 5'd0, 6'd1, '0, '0);
        send_request(OP_QUERY, 5'd0, 5'd0, '0, '0, '0);
        send_request(OP_PROP, '0, '0, '0, '0, '0);
    endtask

    // A ban left on the stack while the column count shrinks.
    task automatic test_stale_entry();
        set_geometry(7'd4, 7'd4, 7'd4);
        send_request(OP_CLEAR, '0, '0, '0, '0, '0);
        send_request(OP_BAN, 5'd3, 5'd3, 6'd1, '0, '0);
        wait_drained();
        write_register(REG_COLS, 7'd2);
        send_request(OP_PROP, '0, '0, '0, '0, '0);
        send_request(OP_QUERY, 5'd1, 5'd1, '0, '0, '0);
    endtask

    task automatic test_clamped_registers();
        set_geometry(7'd0, 7'd63, 7'd0);
        send_request(OP_CLEAR, '0, '0, '0, '0, '0);
        send_request(OP_BAN, 5'd0, 5'd7, 6'd0, '0, '0);
        send_request(OP_PROP, '0, '0, '0, '0, '0);
        send_request(OP_QUERY, 5'd0, 5'd8, '0, '0, '0);
        set_geometry(7'h7F, 7'd64, 7'd127);
        send_request(OP_CLEAR, '0, '0, '0, '0, '0);
        send_request(OP_BAN, 5'd4, 5'd0, 6'd9, '0, '0);
        send_request(OP_PROP, '0, '0, '0, '0, '0);
        send_request(OP_QUERY, 5'd5, 5'd0, '0, '0, '0);
    endtask

    task automatic test_random_phases(int total);
        int sent, rows, cols, pats, density, r;
        sent = 0;
        while (sent < total) begin
            rows = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : $urandom_range(1, 4);
            cols = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : $urandom_range(1, 4);
            pats = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            set_geometry(7'(rows) | (7'($urandom_range(0, 1)) << 6),
                         7'(cols) | (7'($urandom_range(0, 1)) << 6), 7'(pats));
            density = $urandom_range(0, 2);
            for (int i = 0; i < 4; i++) begin
                send_request(OP_LOAD, 5'($urandom), 5'($urandom), 6'($urandom_range(0, pats - 1)),
                             2'($urandom), random_rule(density));
            end
            send_request(OP_CLEAR, 5'($urandom), 5'($urandom), 6'($urandom), 2'($urandom), '0);
            sent += 5;
            for (int i = 0; i < 50; i++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    send_request(OP_BAN, 5'($urandom_range(0, rows - 1)),
                                 5'($urandom_range(0, cols - 1)),
                                 6'($urandom_range(0, pats - 1)), 2'($urandom), '0);
                end else if (r < 70) begin
                    send_request(OP_PROP, '0, '0, '0, '0, '0);
                end else if (r < 90) begin
                    send_request(OP_QUERY, 5'($urandom_range(0, rows - 1)),
                                 5'($urandom_range(0, cols - 1)), '0, '0, '0);
                end else begin
                    send_request(3'($urandom_range(1, 7)), 5'($urandom), 5'($urandom),
                                 6'($urandom), 2'($urandom), {$urandom, $urandom});
                end
                sent++;
            end
            send_request(OP_PROP, '0, '0, '0, '0, '0);
            sent++;
        end
    endtask

    // The receiver holds off while queries keep coming, so the input backs up.
    task automatic test_output_hold();
        set_geometry(7'd2, 7'd3, 7'd6);
        send_request(OP_CLEAR, '0, '0, '0, '0, '0);
        burst_mode = 1;
        long_hold <= 400;
        for (int i = 0; i < 30; i++)
            send_request(OP_QUERY, 5'($urandom_range(0, 1)), 5'($urandom_range(0, 2)), '0, '0, '0);
        burst_mode = 0;
        wait_drained();
        send_request(OP_QUERY, 5'd1, 5'd2, '0, '0, '0);
    endtask

    always @(posedge i_clk) begin
        if (long_hold > 0) begin
            i_out_stall <= 1'b1;
            long_hold <= long_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: i_out_stall <= 1'b0;
                5, 6, 7, 8: i_out_stall <= ($urandom_range(0, 1) == 1);
                default: i_out_stall <= ($urandom_range(0, 30) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result mask=%h left=%0d contra=%b", $time,
                         o_options_mask, o_options_left, o_contradiction);
                error_count++;
            end else begin
                grid_result_t want;
                want = expected_results.pop_front();
                if (o_options_mask !== want.mask) begin
                    $display("%0t: options_mask expected %h actual %h", $time,
                             want.mask, o_options_mask);
                    error_count++;
                end
                if (o_options_left !== want.left) begin
                    $display("%0t: options_left expected %0d actual %0d", $time,
                             want.left, o_options_left);
                    error_count++;
                end
                if (o_contradiction !== want.contra) begin
                    $display("%0t: contradiction expected %b actual %b", $time,
                             want.contra, o_contradiction);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_op        = '0;
        i_cell_row  = '0;
        i_cell_col  = '0;
        i_pattern   = '0;
        i_direction = '0;
        i_rule_mask = '0;
        i_out_stall = 1'b0;
        m_rows  = 7'd32;
        m_cols  = 7'd32;
        m_pats  = 7'd64;
        m_empty = 1'b0;
        for (int i = 0; i < NPAT * 4; i++) m_rules[i] = '0;
        for (int i = 0; i < NCELL; i++) begin
            m_options[i] = '0;
            for (int p = 0; p < NPAT; p++)
                for (int d = 0; d < 4; d++) m_support[i][p][d] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rule_table();
        test_full_grid();
        test_ban_cases();
        test_contradiction();
        test_stale_entry();
        test_clamped_registers();
        test_output_hold();
        test_random_phases(1500);
        wait_drained();

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
